FILE: src/csu_pkg.sv
// Shared types and constants for the comment stripper.
`default_nettype none
package csu_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;

  localparam logic [1:0] KIND_CODE    = 2'd0;
  localparam logic [1:0] KIND_COMMENT = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  typedef enum logic [4:0] {
    MODE_CODE       = 5'b00001,
    MODE_CODE_SLASH = 5'b00010,
    MODE_LINE       = 5'b00100,
    MODE_BLOCK      = 5'b01000,
    MODE_BLOCK_STAR = 5'b10000
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [1:0] kind;
    logic       fin;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
    scan_mode_t mode;
  } decode_t;

endpackage
`default_nettype wire

FILE: src/comment_stripper_unit.sv
// Comment stripper top level: scan-mode register and result queue.
//
// Input channel (in_valid/in_ready): one source byte per item, with
// in_end_of_text on the final byte of a text. Result channel
// (out_valid/out_ready): code bytes, comment bytes and the end-only marker,
// each with out_final_result on the last result of the text.
// Each accepted byte is decided in the cycle it is accepted; its zero, one
// or two results are written to a four-entry result queue, so every result
// is registered in the queue before it is offered on the result channel.
// Throughput is one byte per cycle while the receiver keeps up; in_ready
// depends only on the queue fill (at least two free entries), so a byte
// that yields two results slows the stream only if the queue backs up.
// When the receiver stalls, the queue fills and in_ready drops; nothing
// is lost. Reset empties the queue and returns to plain code mode; after
// the last byte of a text the scanner is back in code mode as well.
`default_nettype none
module comment_stripper_unit
  import csu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char_in,
  input  wire logic       in_end_of_text,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char_out,
  output logic [1:0]      out_stream_kind,
  output logic            out_final_result
);

  scan_mode_t mode_r, mode_nxt;
  decode_t    dec;
  result_t    ent_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;

  csu_decode u_decode (
    .mode (mode_r),
    .ch   (in_char_in),
    .last (in_end_of_text),
    .dec  (dec)
  );

  assign in_ready  = (cnt_r <= 3'd2);
  assign push      = in_valid && in_ready;
  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid && out_ready;

  assign out_char_out     = ent_r[rd_ptr_r].ch;
  assign out_stream_kind  = ent_r[rd_ptr_r].kind;
  assign out_final_result = ent_r[rd_ptr_r].fin;

  always_comb begin
    mode_nxt   = mode_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      mode_nxt   = dec.mode;
      wr_ptr_nxt = wr_ptr_r + dec.num;
      cnt_nxt    = cnt_nxt + {1'b0, dec.num};
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 2'd1;
      cnt_nxt    = cnt_nxt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_CODE;
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      mode_r   <= mode_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (push && dec.num != 2'd0) begin
      ent_r[wr_ptr_r] <= dec.r0;
      if (dec.num == 2'd2) begin
        ent_r[wr_ptr_r + 2'd1] <= dec.r1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/csu_decode.sv
// Per-byte decision: next scan mode and up to two result items.
`default_nettype none
module csu_decode
  import csu_pkg::*;
(
  input  wire scan_mode_t mode,
  input  wire logic [7:0] ch,
  input  wire logic       last,
  output decode_t         dec
);

  result_t    r0;
  result_t    r1;
  result_t    extra;
  logic [1:0] num;
  logic       has_extra;
  scan_mode_t nmode;

  always_comb begin
    r0        = '{ch: ch, kind: KIND_CODE, fin: 1'b0};
    r1        = '{ch: ch, kind: KIND_CODE, fin: 1'b0};
    extra     = '{ch: CH_SLASH, kind: KIND_CODE, fin: 1'b0};
    num       = 2'd0;
    nmode     = mode;
    has_extra = 1'b0;

    case (mode)
      MODE_CODE_SLASH: begin
        if (ch == CH_SLASH) begin
          nmode = MODE_LINE;
        end else if (ch == CH_STAR) begin
          nmode = MODE_BLOCK;
        end else begin
          r0    = '{ch: CH_SLASH, kind: KIND_CODE, fin: 1'b0};
          num   = 2'd2;
          nmode = MODE_CODE;
        end
      end
      MODE_LINE: begin
        if (ch == CH_NL) begin
          r0    = '{ch: CH_NL, kind: KIND_COMMENT, fin: 1'b0};
          r1    = '{ch: CH_NL, kind: KIND_CODE, fin: 1'b0};
          num   = 2'd2;
          nmode = MODE_CODE;
        end else begin
          r0.kind = KIND_COMMENT;
          num     = 2'd1;
        end
      end
      MODE_BLOCK: begin
        if (ch == CH_STAR) begin
          nmode = MODE_BLOCK_STAR;
        end else begin
          r0.kind = KIND_COMMENT;
          num     = 2'd1;
        end
      end
      MODE_BLOCK_STAR: begin
        r0 = '{ch: CH_STAR, kind: KIND_COMMENT, fin: 1'b0};
        r1.kind = KIND_COMMENT;
        if (ch == CH_SLASH) begin
          nmode = MODE_CODE;
        end else if (ch == CH_STAR) begin
          num = 2'd1;
        end else begin
          num   = 2'd2;
          nmode = MODE_BLOCK;
        end
      end
      default: begin
        if (ch == CH_SLASH) begin
          nmode = MODE_CODE_SLASH;
        end else begin
          num   = 2'd1;
          nmode = MODE_CODE;
        end
      end
    endcase

    if (last) begin
      // close whatever is still open at end of text
      case (nmode)
        MODE_CODE_SLASH: begin
          extra     = '{ch: CH_SLASH, kind: KIND_CODE, fin: 1'b0};
          has_extra = 1'b1;
        end
        MODE_LINE: begin
          extra     = '{ch: CH_NL, kind: KIND_COMMENT, fin: 1'b0};
          has_extra = 1'b1;
        end
        MODE_BLOCK_STAR: begin
          extra     = '{ch: CH_STAR, kind: KIND_COMMENT, fin: 1'b0};
          has_extra = 1'b1;
        end
        default: begin
          has_extra = 1'b0;
        end
      endcase
      if (has_extra) begin
        if (num == 2'd0) begin
          r0 = extra;
        end else begin
          r1 = extra;
        end
        num = num + 2'd1;
      end
      if (num == 2'd0) begin
        r0  = '{ch: 8'h00, kind: KIND_END, fin: 1'b0};
        num = 2'd1;
      end
      if (num == 2'd1) begin
        r0.fin = 1'b1;
      end else begin
        r1.fin = 1'b1;
      end
      nmode = MODE_CODE;
    end

    dec = '{num: num, r0: r0, r1: r1, mode: nmode};
  end

endmodule
`default_nettype wire
